@@ rtl/mueller_muller_symbol_timing_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Mueller-Muller symbol timing block
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MUELLER_MULLER_SYMBOL_TIMING_ASSERT_SVH
`define MUELLER_MULLER_SYMBOL_TIMING_ASSERT_SVH
`ifndef SYNTH
// A condition that holds at every clock edge out of reset.
`define MMST_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mmst check failed");
// A consequence that holds in the same cycle as its cause.
`define MMST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmst check failed");
// A consequence that holds in the cycle after its cause.
`define MMST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmst check failed");
`else
`define MMST_ASSERT(label, clk, rst_n, prop)
`define MMST_IMPLY(label, clk, rst_n, ante, cons)
`define MMST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mmst_pkg.sv @@
// ----------------------------------------------------------------------------
// Mueller-Muller symbol timing package
// Register map, fixed field widths, reset values and shared types.
// ----------------------------------------------------------------------------
package mmst_pkg;

	localparam int SPS_W       = 5;
	localparam int GAIN_W      = 16;
	localparam int DEV_W       = 20;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;

	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 31;

	localparam logic [CFG_INDEX_W-1:0] REG_SPS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BETA  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DEV   = 2'd3;

	localparam logic [SPS_W-1:0]  SPS_RESET   = 5'd4;
	localparam logic [GAIN_W-1:0] ALPHA_RESET = 16'd26;
	localparam logic [GAIN_W-1:0] BETA_RESET  = 16'd2570;
	localparam logic [DEV_W-1:0]  DEV_RESET   = 20'd1311;

	// Steps of the loop update sequencer.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_INTERP_I,
		BK_INTERP_Q,
		BK_ERROR,
		BK_OMEGA,
		BK_PHASE
	} bk_state_t;

	// Countdown handed back to the sample front end after a strobe.
	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
	} adv_t;

endpackage

@@ rtl/mmst_fifo.sv @@
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module mmst_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				2'b00, 2'b11: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/mmst_front.sv @@
// ----------------------------------------------------------------------------
// Sample front end
// Holds the previous sample and the strobe countdown, picks strobe samples.
// ----------------------------------------------------------------------------
module mmst_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [SAMPLE_BITS-1:0]     sample_i,
	input  logic signed [SAMPLE_BITS-1:0]     sample_q,
	input  logic [mmst_pkg::SPS_W-1:0]        sps,
	output logic                              job_push,
	output logic [4*SAMPLE_BITS-1:0]          job_data,
	input  logic                              job_full,
	input  mmst_pkg::adv_t                    adv
);
	import mmst_pkg::*;

	logic                          accept;
	logic                          fire;
	logic                          wait_q;
	logic                          primed_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [SAMPLE_BITS-1:0] held_i_q;
	logic signed [SAMPLE_BITS-1:0] held_q_q;
	logic [SPS_W:0]                sps_p1;

	// While a strobe is in the loop, the next countdown is not known yet.
	assign full     = wait_q | job_full;
	assign accept   = push & ~full;
	assign sps_p1   = {1'b0, sps} + (SPS_W + 1)'(1);
	assign job_push = accept & fire;
	assign job_data = {sample_i, sample_q, held_i_q, held_q_q};

	always_comb begin
		if (primed_q) begin
			fire = (count_q == '0);
		end else begin
			fire = ({1'b0, count_q} >= sps_p1) || (count_q == COUNT_W'(COUNT_MAX));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q   <= 1'b0;
			primed_q <= 1'b0;
			count_q  <= '0;
			held_i_q <= '0;
			held_q_q <= '0;
		end else begin
			if (adv.valid) begin
				count_q <= adv.count;
				wait_q  <= 1'b0;
			end else if (accept) begin
				held_i_q <= sample_i;
				held_q_q <= sample_q;
				if (fire) begin
					wait_q   <= 1'b1;
					primed_q <= 1'b1;
				end else if (primed_q) begin
					count_q <= count_q - 1'b1;
				end else if (count_q != COUNT_W'(COUNT_MAX)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/mmst_back.sv @@
// ----------------------------------------------------------------------------
// Timing loop back end
// Interpolates the strobe sample, forms the error and updates omega and mu.
// ----------------------------------------------------------------------------
module mmst_back #(
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [mmst_pkg::SPS_W-1:0]            sps,
	input  logic [mmst_pkg::GAIN_W-1:0]           alpha,
	input  logic [mmst_pkg::GAIN_W-1:0]           beta,
	input  logic [mmst_pkg::DEV_W-1:0]            dev,
	input  logic                                  job_empty,
	input  logic [4*SAMPLE_BITS-1:0]              job_data,
	output logic                                  job_pop,
	input  logic                                  res_full,
	output logic                                  res_push,
	output logic [SAMPLE_BITS+PHASE_FRAC_BITS:0]  res_data,
	output mmst_pkg::adv_t                        adv
);
	import mmst_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int PFB  = PHASE_FRAC_BITS;
	localparam int EF   = SB - 3;
	localparam int EW   = SB + 2;
	localparam int DW   = SB + 1;
	localparam int PW   = DW + PFB + 1;
	localparam int GPW  = GAIN_W + SB;
	localparam int OMEGA_W = ((SPS_W + PFB) > DEV_W ? (SPS_W + PFB) : DEV_W) + 1;
	localparam int OW2  = OMEGA_W + 2;
	localparam int ERR_ONE_I = 1 << EF;

	localparam logic signed [EW-1:0]  ERR_HI    = EW'(ERR_ONE_I);
	localparam logic signed [EW-1:0]  ERR_LO    = -ERR_HI;
	localparam logic [OMEGA_W-1:0]    OMEGA_RST = OMEGA_W'(SPS_RESET) << PFB;
	localparam logic signed [OW2-1:0] CNT_LIM   = OW2'(COUNT_MAX);

	bk_state_t state_q, state_d;

	logic signed [SB-1:0]   s_i_q, s_q_q, h_i_q, h_q_q;
	logic signed [SB-1:0]   x_i_q, x_q_q;
	logic signed [SB-1:0]   last_i_q, last_q_q;
	logic                   ldec_i_q, ldec_q_q, primed_q;
	logic signed [SB-2:0]   err_q;
	logic [OMEGA_W-1:0]     omega_q;
	logic [PFB-1:0]         mu_q;

	logic signed [SB-1:0]   h_sel, n_sel, x_new;
	logic signed [DW-1:0]   diff;
	logic signed [PW-1:0]   iprod;
	logic signed [EW-1:0]   t_i, t_q, p_i, p_q, xi_e, xq_e, esum, eclamp;
	logic signed [SB-2:0]   err_new;
	logic [GAIN_W-1:0]      gain;
	logic signed [GPW-1:0]  gprod, gsh;
	logic signed [OW2-1:0]  gterm, mid_s, dev_s, lo_raw, lo, hi, osum, oclamp;
	logic [OMEGA_W-1:0]     omega_new;
	logic signed [OW2-1:0]  mu_s, om_s, tsum, advv, adv_m1;
	logic [PFB-1:0]         mu_new;
	logic [COUNT_W-1:0]     count_new;
	logic                   adv_valid;

	// Interpolation: held + floor((new - held) * mu), one part per step.
	assign h_sel = (state_q == BK_INTERP_Q) ? h_q_q : h_i_q;
	assign n_sel = (state_q == BK_INTERP_Q) ? s_q_q : s_i_q;
	assign diff  = DW'(n_sel) - DW'(h_sel);
	assign iprod = PW'(diff) * PW'($signed({1'b0, mu_q}));
	assign x_new = h_sel + $signed(iprod[PFB +: SB]);

	// Error from the two strobes and their decisions.
	always_comb begin
		xi_e = EW'(x_i_q);
		xq_e = EW'(x_q_q);
		t_i  = x_i_q[SB-1] ? -EW'(last_i_q) : EW'(last_i_q);
		t_q  = x_q_q[SB-1] ? -EW'(last_q_q) : EW'(last_q_q);
		p_i  = !primed_q ? '0 : (ldec_i_q ? xi_e : -xi_e);
		p_q  = !primed_q ? '0 : (ldec_q_q ? xq_e : -xq_e);
		esum = t_i + t_q + p_i + p_q;
		if (esum > ERR_HI) begin
			eclamp = ERR_HI;
		end else if (esum < ERR_LO) begin
			eclamp = ERR_LO;
		end else begin
			eclamp = esum;
		end
		err_new = eclamp[SB-2:0];
	end

	// One gain multiplier serves beta in the omega step and alpha in the phase step.
	assign gain  = (state_q == BK_OMEGA) ? beta : alpha;
	assign gprod = GPW'($signed({1'b0, gain})) * GPW'(err_q);
	assign gsh   = gprod >>> EF;
	assign gterm = OW2'(gsh);

	always_comb begin
		mid_s  = OW2'(sps) << PFB;
		dev_s  = OW2'(dev);
		lo_raw = mid_s - dev_s;
		lo     = (lo_raw < 0) ? '0 : lo_raw;
		hi     = mid_s + dev_s;
		osum   = OW2'(omega_q) + gterm;
		if (osum > hi) begin
			oclamp = hi;
		end else if (osum < lo) begin
			oclamp = lo;
		end else begin
			oclamp = osum;
		end
		omega_new = oclamp[OMEGA_W-1:0];
	end

	always_comb begin
		mu_s   = OW2'(mu_q);
		om_s   = OW2'(omega_q);
		tsum   = mu_s + om_s + gterm;
		advv   = tsum >>> PFB;
		adv_m1 = advv - OW2'(1);
		mu_new = tsum[PFB-1:0];
		if (adv_m1 < 0) begin
			count_new = '0;
		end else if (adv_m1 > CNT_LIM) begin
			count_new = COUNT_W'(COUNT_MAX);
		end else begin
			count_new = adv_m1[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		res_push  = 1'b0;
		adv_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = BK_INTERP_I;
				end
			end
			BK_INTERP_I: state_d = BK_INTERP_Q;
			BK_INTERP_Q: state_d = BK_ERROR;
			BK_ERROR:    state_d = BK_OMEGA;
			BK_OMEGA:    state_d = BK_PHASE;
			BK_PHASE: begin
				if (!res_full) begin
					res_push  = 1'b1;
					adv_valid = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign adv       = {adv_valid, count_new};
	assign res_data  = {x_i_q[SB-1], x_q_q[SB-1], err_q, mu_new};

	always_ff @(posedge clk) begin
		if (job_pop) begin
			{s_i_q, s_q_q, h_i_q, h_q_q} <= job_data;
		end
		if (state_q == BK_INTERP_I) begin
			x_i_q <= x_new;
		end
		if (state_q == BK_INTERP_Q) begin
			x_q_q <= x_new;
		end
		if (state_q == BK_ERROR) begin
			err_q <= err_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q  <= OMEGA_RST;
			mu_q     <= '0;
			last_i_q <= '0;
			last_q_q <= '0;
			ldec_i_q <= 1'b0;
			ldec_q_q <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (state_q == BK_OMEGA) begin
				omega_q <= omega_new;
			end
			if (res_push) begin
				mu_q     <= mu_new;
				last_i_q <= x_i_q;
				last_q_q <= x_q_q;
				ldec_i_q <= x_i_q[SB-1];
				ldec_q_q <= x_q_q[SB-1];
				primed_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/mueller_muller_symbol_timing.sv @@
// ----------------------------------------------------------------------------
// Mueller-Muller symbol timing recovery
// Picks one interpolated symbol per strobe from a complex sample stream.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Beat carries
// -------   ------------------   ----------------------------------------------
// samples   push / full          sample_i, sample_q
// results   pop / empty          decision_i, decision_q, timing_error,
//                                fractional_phase
// config    cfg_write            cfg_index, cfg_data
//
// A sample that is not a strobe is taken as soon as full is low. A strobe
// sample raises full until its countdown comes back: the job leaves the job
// queue, then passes the five steps of the loop sequencer in the back end (two
// interpolation steps on one multiplier, error, omega with beta, phase with
// alpha on the shared gain multiplier). Reset sets the configuration registers
// to their defaults, omega to the default period and mu and the last strobe
// to zero at once; there is no clearing pass. A full result queue holds the
// back end in its phase step, which in turn keeps full high toward the samples.
// Structure: the front end counts samples and picks strobes. A strobe beat goes
// as a job through a two-entry queue to the back end, which returns the next
// countdown to the front end and writes its result beat into a two-entry
// output queue. Configuration is meant to be written only while the block is
// idle.
// ----------------------------------------------------------------------------
`include "mueller_muller_symbol_timing_assert.svh"

module mueller_muller_symbol_timing #(
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [SAMPLE_BITS-1:0]         sample_i,
	input  logic signed [SAMPLE_BITS-1:0]         sample_q,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  decision_i,
	output logic                                  decision_q,
	output logic signed [SAMPLE_BITS-2:0]         timing_error,
	output logic [PHASE_FRAC_BITS-1:0]            fractional_phase,
	input  logic                                  cfg_write,
	input  logic [mmst_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mmst_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mmst_pkg::*;

	localparam int JOB_W = 4 * SAMPLE_BITS;
	localparam int RES_W = SAMPLE_BITS + PHASE_FRAC_BITS + 1;

	// Configuration registers.
	logic [SPS_W-1:0]  sps_q;
	logic [GAIN_W-1:0] alpha_q;
	logic [GAIN_W-1:0] beta_q;
	logic [DEV_W-1:0]  dev_q;

	// Job queue between front and back end.
	logic             job_push;
	logic             job_pop;
	logic             job_full;
	logic             job_empty;
	logic [JOB_W-1:0] job_wr;
	logic [JOB_W-1:0] job_rd;

	// Result queue toward the output.
	logic             res_push;
	logic             res_full;
	logic [RES_W-1:0] res_wr;
	logic [RES_W-1:0] res_rd;

	adv_t adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q   <= SPS_RESET;
			alpha_q <= ALPHA_RESET;
			beta_q  <= BETA_RESET;
			dev_q   <= DEV_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SPS:   sps_q   <= cfg_data[SPS_W-1:0];
				REG_ALPHA: alpha_q <= cfg_data[GAIN_W-1:0];
				REG_BETA:  beta_q  <= cfg_data[GAIN_W-1:0];
				REG_DEV:   dev_q   <= cfg_data[DEV_W-1:0];
			endcase
		end
	end

	mmst_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample_i (sample_i),
		.sample_q (sample_q),
		.sps      (sps_q),
		.job_push (job_push),
		.job_data (job_wr),
		.job_full (job_full),
		.adv      (adv)
	);

	mmst_fifo #(
		.W     (JOB_W),
		.DEPTH (2)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_wr),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	mmst_back #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sps       (sps_q),
		.alpha     (alpha_q),
		.beta      (beta_q),
		.dev       (dev_q),
		.job_empty (job_empty),
		.job_data  (job_rd),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wr),
		.adv       (adv)
	);

	mmst_fifo #(
		.W     (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	// Result beat layout: decisions, clamped error, updated mu.
	assign decision_i       = res_rd[RES_W-1];
	assign decision_q       = res_rd[RES_W-2];
	assign timing_error     = res_rd[PHASE_FRAC_BITS +: SAMPLE_BITS-1];
	assign fractional_phase = res_rd[PHASE_FRAC_BITS-1:0];

	// A strobe job never meets a full job queue.
	`MMST_IMPLY(a_job_room, clk, arst_n, job_push, !job_full)
	// A strobe holds off further samples until its countdown comes back.
	`MMST_NEXT(a_strobe_stalls, clk, arst_n, job_push, full)
	// The countdown returns exactly when the result beat is written.
	`MMST_IMPLY(a_adv_with_result, clk, arst_n, adv.valid, res_push)
	// The back end only writes results into a queue with room.
	`MMST_ASSERT(a_res_room, clk, arst_n, !(res_push && res_full))

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Mueller-Muller symbol timing block
// Streams complex samples into the block, predicts every strobe beat with an
// independent fixed-point model of the timing loop, and checks each result
// beat in order while both handshakes idle at random in some phases and stall.
// ----------------------------------------------------------------------------
module testbench;
	import mmst_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 16;
	localparam int ERR_FRAC = SAMPLE_W - 3;
	localparam longint ERR_ONE   = longint'(1) << ERR_FRAC;
	localparam longint PHASE_ONE = longint'(1) << PHASE_W;

	// Settling time after the last owed beat, well past the time that a strobe keeps full high.
	localparam int SETTLE_CYCLES  = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT   = 10;
	localparam int DIR_ROWS       = 24;

	// One result beat: the two sign decisions, the clamped error and mu.
	typedef struct packed {
		logic                       dec_i;
		logic                       dec_q;
		logic signed [SAMPLE_W-2:0] err;
		logic [PHASE_W-1:0]         phase;
	} symbol_beat_t;

	// One row of the directed stimulus. Where typed is set, the row carries
	// the result beat written out by hand instead of the predicted one.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] si;
		logic signed [SAMPLE_W-1:0] sq;
		logic                       typed;
		symbol_beat_t               want;
	} dir_row_t;

	localparam symbol_beat_t NO_BEAT = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic signed [SAMPLE_W-1:0] sample_i;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic empty;
	logic pop;
	logic decision_i;
	logic decision_q;
	logic signed [SAMPLE_W-2:0] timing_error;
	logic [PHASE_W-1:0] fractional_phase;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mueller_muller_symbol_timing #(
		.SAMPLE_BITS     (SAMPLE_W),
		.PHASE_FRAC_BITS (PHASE_W)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.sample_i         (sample_i),
		.sample_q         (sample_q),
		.empty            (empty),
		.pop              (pop),
		.decision_i       (decision_i),
		.decision_q       (decision_q),
		.timing_error     (timing_error),
		.fractional_phase (fractional_phase),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Configuration as the loop model sees it.
	logic [SPS_W-1:0]  sps_reg;
	logic [GAIN_W-1:0] alpha_reg;
	logic [GAIN_W-1:0] beta_reg;
	logic [DEV_W-1:0]  dev_reg;

	// Loop state of the model. The period estimate is kept one bit wider than
	// the whole-sample part needs so that the widest deviation cannot wrap.
	logic signed [SAMPLE_W-1:0] prior_i, prior_q;
	logic signed [SAMPLE_W-1:0] strobe_x_i, strobe_x_q;
	logic strobe_d_i, strobe_d_q;
	logic [PHASE_W-1:0] mu_acc;
	logic [21:0] omega_est;
	logic [COUNT_W-1:0] skip_count;
	logic locked;

	// Result beats owed by the block, oldest first.
	symbol_beat_t owed_strobes[$];

	int fail_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit rx_hold_request = 1'b0;
	int rx_hold_left;

	// The directed part runs on the reset configuration (four samples per
	// symbol). Samples 0 to 4 only count up, and sample 5 is the first strobe.
	// With mu still zero the strobe value is exactly sample 4, and with no
	// previous decision the error is zero, so omega stays at 4.0, the advance
	// is 4 and mu stays zero: that beat is written out below. Sample 4 sits at
	// both extremes of the range. Later strobes follow the loop and are left
	// to the model.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{16'sd0,      16'sd0,      1'b0, NO_BEAT},
		'{16'sh7FFF,   16'sh7FFF,   1'b0, NO_BEAT},
		'{16'sh8000,   16'sh8000,   1'b0, NO_BEAT},
		'{16'sd1,      -16'sd1,     1'b0, NO_BEAT},
		'{16'sh8000,   16'sh7FFF,   1'b0, NO_BEAT},
		'{16'sh7FFF,   16'sh8000,   1'b1, '{1'b1, 1'b0, 15'sd0, 16'd0}},
		'{-16'sd1,     16'sd0,      1'b0, NO_BEAT},
		'{16'sd0,      -16'sd1,     1'b0, NO_BEAT},
		'{16'sh7FFF,   16'sh7FFF,   1'b0, NO_BEAT},
		'{16'sh8000,   16'sh8000,   1'b0, NO_BEAT},
		'{16'sd8192,   -16'sd8192,  1'b0, NO_BEAT},
		'{16'sd8192,   -16'sd8192,  1'b0, NO_BEAT},
		'{-16'sd8192,  16'sd8192,   1'b0, NO_BEAT},
		'{-16'sd8192,  16'sd8192,   1'b0, NO_BEAT},
		'{16'sd4096,   16'sd4096,   1'b0, NO_BEAT},
		'{-16'sd4096,  16'sd12000,  1'b0, NO_BEAT},
		'{16'sh5555,   16'shAAAA,   1'b0, NO_BEAT},
		'{16'shAAAA,   16'sh5555,   1'b0, NO_BEAT},
		'{16'sd100,    -16'sd100,   1'b0, NO_BEAT},
		'{-16'sd16384, -16'sd16384, 1'b0, NO_BEAT},
		'{16'sd16384,  16'sd16384,  1'b0, NO_BEAT},
		'{16'sh7FFF,   16'sh8000,   1'b0, NO_BEAT},
		'{16'sh8000,   16'sh7FFF,   1'b0, NO_BEAT},
		'{16'sd0,      16'sd0,      1'b0, NO_BEAT}
	};

	// Advances the loop model by one sample. Returns 1 and fills beat when
	// the sample is a strobe.
	function automatic bit predict_strobe(input logic signed [SAMPLE_W-1:0] si,
			input logic signed [SAMPLE_W-1:0] sq, output symbol_beat_t beat);
		bit fire;
		longint xi, xq, err, sgn_i, sgn_q, mid, lo, hi, om, t, adv;
		logic di, dq;
		beat = NO_BEAT;
		// Before the first strobe the counter counts samples up and saturates;
		// afterwards it counts down to the next strobe.
		if (locked)
			fire = (skip_count == 0);
		else
			fire = (int'(skip_count) >= int'(sps_reg) + 1) || (int'(skip_count) >= COUNT_MAX);
		if (!fire) begin
			if (locked)
				skip_count = skip_count - 1'b1;
			else if (int'(skip_count) < COUNT_MAX)
				skip_count = skip_count + 1'b1;
			prior_i = si;
			prior_q = sq;
			return 1'b0;
		end
		// Linear interpolation between the held sample and the new one at mu;
		// the arithmetic shift floors.
		xi = (longint'(prior_i) * (PHASE_ONE - longint'(mu_acc)) +
			longint'(si) * longint'(mu_acc)) >>> PHASE_W;
		xq = (longint'(prior_q) * (PHASE_ONE - longint'(mu_acc)) +
			longint'(sq) * longint'(mu_acc)) >>> PHASE_W;
		di = (xi < 0);
		dq = (xq < 0);
		// The decision before the first strobe counts as zero.
		sgn_i = locked ? (strobe_d_i ? -1 : 1) : 0;
		sgn_q = locked ? (strobe_d_q ? -1 : 1) : 0;
		err = (di ? -longint'(strobe_x_i) : longint'(strobe_x_i)) +
			(dq ? -longint'(strobe_x_q) : longint'(strobe_x_q)) - sgn_i * xi - sgn_q * xq;
		if (err > ERR_ONE)
			err = ERR_ONE;
		if (err < -ERR_ONE)
			err = -ERR_ONE;
		// Period estimate: integral step, then the window around the nominal
		// period, whose low side never drops below zero.
		mid = longint'(sps_reg) << PHASE_W;
		lo = mid - longint'(dev_reg);
		if (lo < 0)
			lo = 0;
		hi = mid + longint'(dev_reg);
		om = longint'(omega_est) + ((longint'(beta_reg) * err) >>> ERR_FRAC);
		if (om > hi)
			om = hi;
		if (om < lo)
			om = lo;
		omega_est = om[21:0];
		// Phase step: the whole part is the advance, the fraction stays as mu.
		t = longint'(mu_acc) + om + ((longint'(alpha_reg) * err) >>> ERR_FRAC);
		adv = (t >>> PHASE_W) - 1;
		if (adv < 0)
			adv = 0;
		if (adv > COUNT_MAX)
			adv = COUNT_MAX;
		mu_acc = t[PHASE_W-1:0];
		skip_count = adv[COUNT_W-1:0];
		strobe_x_i = xi[SAMPLE_W-1:0];
		strobe_x_q = xq[SAMPLE_W-1:0];
		strobe_d_i = di;
		strobe_d_q = dq;
		locked = 1'b1;
		prior_i = si;
		prior_q = sq;
		beat.dec_i = di;
		beat.dec_q = dq;
		beat.err = err[SAMPLE_W-2:0];
		beat.phase = mu_acc;
		return 1'b1;
	endfunction

	// Offers one sample beat, waits for it to be taken, then records what the
	// block owes for it. The task returns at the accepting rising edge, so
	// push stays high into the next beat unless the caller idles.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
			input logic signed [SAMPLE_W-1:0] sq, input bit typed, input symbol_beat_t typed_beat);
		symbol_beat_t beat;
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (predict_strobe(si, sq, beat))
			owed_strobes.insert(owed_strobes.size(), typed ? typed_beat : beat);
	endtask

	// Waits for every owed beat, then lets the back end settle, since a
	// sample that makes no beat may still be on its way through.
	task automatic wait_drained();
		while (owed_strobes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles while the block is idle.
	task automatic write_regs(input logic [SPS_W-1:0] sps, input logic [GAIN_W-1:0] alpha,
			input logic [GAIN_W-1:0] beta, input logic [DEV_W-1:0] dev);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_SPS;
		cfg_data <= CFG_DATA_W'(sps);
		@(negedge clk);
		cfg_index <= REG_ALPHA;
		cfg_data <= CFG_DATA_W'(alpha);
		@(negedge clk);
		cfg_index <= REG_BETA;
		cfg_data <= CFG_DATA_W'(beta);
		@(negedge clk);
		cfg_index <= REG_DEV;
		cfg_data <= CFG_DATA_W'(dev);
		@(negedge clk);
		cfg_write <= 1'b0;
		sps_reg = sps;
		alpha_reg = alpha;
		beta_reg = beta;
		dev_reg = dev;
	endtask

	// One phase of random stimulus under one setting. Most samples follow a
	// symbol stream: a random level on I and Q held for one nominal period,
	// with a little noise, so that the loop sees real transitions. The rest
	// are full-range noise, which also covers every bit of both fields.
	// rx_hold asks the receiver for a long hold-off at the start; tx_pause
	// stops the sender halfway until every owed beat has come out.
	task automatic run_phase(input logic [SPS_W-1:0] sps, input logic [GAIN_W-1:0] alpha,
			input logic [GAIN_W-1:0] beta, input logic [DEV_W-1:0] dev, input int count,
			input int tx_pct, input int rx_pct, input bit rx_hold, input bit tx_pause);
		int n, run_left, level_i, level_q, amp;
		logic signed [SAMPLE_W-1:0] si, sq;
		@(negedge clk);
		push <= 1'b0;
		wait_drained();
		write_regs(sps, alpha, beta, dev);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (rx_hold)
			rx_hold_request = 1'b1;
		run_left = 0;
		level_i = 0;
		level_q = 0;
		for (n = 0; n < count; n++) begin
			if (tx_pause && n == count / 2) begin
				@(negedge clk);
				push <= 1'b0;
				while (owed_strobes.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(99) < 75) begin
				if (run_left == 0) begin
					amp = $urandom_range(16383, 1024);
					level_i = $urandom_range(1) ? amp : -amp;
					amp = $urandom_range(16383, 1024);
					level_q = $urandom_range(1) ? amp : -amp;
					run_left = (sps_reg > 1) ? int'(sps_reg) : 1;
				end
				run_left--;
				si = SAMPLE_W'(level_i + int'($urandom_range(511)) - 256);
				sq = SAMPLE_W'(level_q + int'($urandom_range(511)) - 256);
			end else begin
				si = SAMPLE_W'($urandom);
				sq = SAMPLE_W'($urandom);
			end
			send_sample(si, sq, 1'b0, NO_BEAT);
		end
	endtask

	// Receiver: decides pop at each falling edge. A hold-off request from the
	// stimulus turns into a counted stretch with pop low.
	initial begin
		pop = 1'b0;
		rx_hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_request) begin
				rx_hold_request = 1'b0;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Result check: every beat taken is compared with the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (owed_strobes.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected strobe beat: d=%b%b err=%0d mu=%0d",
						decision_i, decision_q, timing_error, fractional_phase);
			end else begin
				if (decision_i !== owed_strobes[0].dec_i ||
						decision_q !== owed_strobes[0].dec_q ||
						timing_error !== owed_strobes[0].err ||
						fractional_phase !== owed_strobes[0].phase) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("beat mismatch: want %b%b e=%0d mu=%0d, got %b%b e=%0d mu=%0d",
							owed_strobes[0].dec_i, owed_strobes[0].dec_q, owed_strobes[0].err,
							owed_strobes[0].phase, decision_i, decision_q, timing_error,
							fractional_phase);
				end
				owed_strobes.delete(0);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		sample_i = '0;
		sample_q = '0;
		cfg_write = 1'b0;
		cfg_index = REG_SPS;
		cfg_data = '0;
		sps_reg = SPS_RESET;
		alpha_reg = ALPHA_RESET;
		beta_reg = BETA_RESET;
		dev_reg = DEV_RESET;
		prior_i = '0;
		prior_q = '0;
		strobe_x_i = '0;
		strobe_x_q = '0;
		strobe_d_i = 1'b0;
		strobe_d_q = 1'b0;
		mu_acc = '0;
		omega_est = 22'({SPS_RESET, 16'h0});
		skip_count = '0;
		locked = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily.
		tx_idle_pct = 27;
		rx_idle_pct = 58;
		foreach (dir_rows[r])
			send_sample(dir_rows[r].si, dir_rows[r].sq, dir_rows[r].typed, dir_rows[r].want);
		run_phase(SPS_RESET, ALPHA_RESET, BETA_RESET, DEV_RESET, 60, 27, 58, 1'b0, 1'b0);
		// Shortest legal period with the loop frozen: no gain, no deviation.
		run_phase(5'd2, 16'd0, 16'd0, 20'd0, 60, 27, 58, 1'b0, 1'b1);

		// Now the receiver idles lightly and the sender heavily. Full gains and
		// the widest window, whose low side stays just above zero.
		run_phase(5'd16, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 80, 58, 27, 1'b0, 1'b0);
		// Period zero and no window: omega is pinned at zero, so every sample
		// strobes and a negative error drives the phase sum below zero.
		run_phase(5'd0, 16'hFFFF, 16'd0, 20'd0, 60, 58, 27, 1'b0, 1'b0);

		// No idling from here on. Period one with strong integral gain, and a
		// long receiver hold-off that backs the block up into its input.
		run_phase(5'd1, 16'd1, 16'hFFFF, 20'h10000, 60, 0, 0, 1'b1, 1'b0);
		// Largest period with a wide window, so the advance can pass 32.
		run_phase(5'd31, 16'd300, 16'd4000, 20'h40000, 80, 0, 0, 1'b0, 1'b0);
		repeat (3)
			run_phase(SPS_W'($urandom_range(16, 2)), GAIN_W'($urandom), GAIN_W'($urandom),
				DEV_W'($urandom), 45, 0, 0, 1'b0, 1'b0);

		@(negedge clk);
		push <= 1'b0;
		wait_drained();
		if (fail_count == 0)
			$display("mueller_muller_symbol_timing test passed");
		else
			$display("mueller_muller_symbol_timing test failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("mueller_muller_symbol_timing test failed");
		$finish;
	end

endmodule
